@@ rtl/gcl_pkg.sv @@
// Shared types for the GCD / LCM unit: sequencer states and ALU operations.
`default_nettype none
package gcl_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TWOS,
      ST_ODD_A,
      ST_REDUCE,
      ST_SCALE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage
`default_nettype wire

@@ rtl/gcd_lcm_unit.sv @@
// Top level of the GCD / LCM unit: sequencer, operand registers and shared ALU.
// An operand of zero goes straight to the result strobe; else binary GCD (strip common
//   twos, strip the other twos of a, reduce), scale the gcd back up, divide a by the gcd
//   and multiply (a/gcd)*b, then strobe the result.
// Throughput: one item at a time on one 2*OPERAND_WIDTH adder; busy stays high through
//   the strobe cycle. Reset: synchronous, sequencer to idle; results cannot be stalled.
`default_nettype none
module gcd_lcm_unit
   import gcl_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [OPERAND_WIDTH-1:0] req_operand_a,
   input  wire logic [OPERAND_WIDTH-1:0] req_operand_b,
   output logic                          rsp_valid,
   output logic [15:0]                   rsp_gcd_value,
   output logic [31:0]                   rsp_lcm_value
);

   localparam int W     = OPERAND_WIDTH;
   localparam int AW    = 2 * W;
   localparam int CNT_W = $clog2(W);

   // ---------------------------------------------------------------
   // State
   //   a_ff : operand a, later shifted into the quotient a/gcd
   //   b_ff : operand b, shifted out MSB first as the multiplier
   //   x_ff : odd side of the binary GCD, ends holding the gcd
   //   y_ff : other side of the GCD, then the division remainder
   //   k_ff : count of common factors of two
   //   acc_ff : product accumulator, holds the lcm at the end
   // ---------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [W-1:0]       a_ff, a_in;
   logic [W-1:0]       b_ff, b_in;
   logic [W-1:0]       x_ff, x_in;
   logic [W-1:0]       y_ff, y_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]      acc_ff, acc_in;

   // shared ALU
   alu_op_type         alu_op;
   logic [AW-1:0]      alu_lhs;
   logic [AW-1:0]      alu_rhs;
   logic [AW-1:0]      alu_result;
   logic               alu_carry;

   logic               take;
   logic               zero_operand;
   logic [W+31:0]      gcd_wide;
   logic [AW+31:0]     lcm_wide;

   assign take         = start && !busy;
   assign zero_operand = (req_operand_a == '0) || (req_operand_b == '0);

   gcl_alu #(
      .WIDTH (AW)
   ) u_alu (
      .op     (alu_op),
      .lhs    (alu_lhs),
      .rhs    (alu_rhs),
      .result (alu_result),
      .carry  (alu_carry)
   );

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = zero_operand ? ST_DONE : ST_TWOS;
            end
         end
         ST_TWOS: begin
            if (x_ff[0] || y_ff[0]) begin
               state_in = ST_ODD_A;
            end
         end
         ST_ODD_A: begin
            if (x_ff[0]) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (y_ff == '0) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (k_ff == '0) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Outputs and ALU operand select
   // ---------------------------------------------------------------
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      alu_op    = ALU_ADD;
      alu_lhs   = '0;
      alu_rhs   = '0;
      case (state_ff)
         ST_REDUCE: begin
            // y - x, both odd
            alu_op  = ALU_SUB;
            alu_lhs = {{W{1'b0}}, y_ff};
            alu_rhs = {{W{1'b0}}, x_ff};
         end
         ST_DIVIDE: begin
            // restoring division: {rem, next dividend bit} - gcd
            alu_op  = ALU_SUB;
            alu_lhs = {{(W-1){1'b0}}, y_ff, a_ff[W-1]};
            alu_rhs = {{W{1'b0}}, x_ff};
         end
         ST_MULTIPLY: begin
            // MSB-first shift and add
            alu_op  = ALU_ADD;
            alu_lhs = {acc_ff[AW-2:0], 1'b0};
            alu_rhs = b_ff[W-1] ? {{W{1'b0}}, a_ff} : '0;
         end
         default: begin
            alu_op  = ALU_ADD;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------
   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      k_in   = k_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               a_in   = req_operand_a;
               b_in   = req_operand_b;
               x_in   = zero_operand ? W'(1) : req_operand_a;
               y_in   = req_operand_b;
               k_in   = '0;
               acc_in = '0;
            end
         end
         ST_TWOS: begin
            // strip factors of two common to both
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = {1'b0, x_ff[W-1:1]};
               y_in = {1'b0, y_ff[W-1:1]};
               k_in = k_ff + CNT_W'(1);
            end
         end
         ST_ODD_A: begin
            if (!x_ff[0]) begin
               x_in = {1'b0, x_ff[W-1:1]};
            end
         end
         ST_REDUCE: begin
            if (y_ff != '0) begin
               if (!y_ff[0]) begin
                  y_in = {1'b0, y_ff[W-1:1]};
               end else if (alu_carry) begin
                  y_in = alu_result[W-1:0];
               end else begin
                  // y < x: swap so the subtract never goes negative
                  x_in = y_ff;
                  y_in = x_ff;
               end
            end
         end
         ST_SCALE: begin
            if (k_ff != '0) begin
               x_in = {x_ff[W-2:0], 1'b0};
               k_in = k_ff - CNT_W'(1);
            end else begin
               y_in   = '0;
               cnt_in = CNT_W'(W - 1);
            end
         end
         ST_DIVIDE: begin
            a_in = {a_ff[W-2:0], alu_carry};
            if (alu_carry) begin
               y_in = alu_result[W-1:0];
            end else begin
               y_in = {y_ff[W-2:0], a_ff[W-1]};
            end
            if (cnt_ff == '0) begin
               cnt_in = CNT_W'(W - 1);
               acc_in = '0;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_MULTIPLY: begin
            acc_in = alu_result;
            b_in   = {b_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         default: begin
            a_in = a_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
   end

   // results taken straight from the working registers, fitted to field widths
   assign gcd_wide      = {32'd0, x_ff};
   assign lcm_wide      = {32'd0, acc_ff};
   assign rsp_gcd_value = gcd_wide[15:0];
   assign rsp_lcm_value = lcm_wide[31:0];

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_strobe_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("unit still busy after delivering a result");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted but unit not busy");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (x_ff != '0))
      else $error("divide step entered with zero gcd");

endmodule
`default_nettype wire

@@ rtl/gcl_alu.sv @@
// Shared adder/subtractor used by the reduce, divide and multiply steps of the GCD / LCM sequencer.
`default_nettype none
module gcl_alu
   import gcl_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  alu_op_type       op,
   input  logic [WIDTH-1:0] lhs,
   input  logic [WIDTH-1:0] rhs,
   output logic [WIDTH-1:0] result,
   output logic             carry
);

   logic             is_sub;
   logic [WIDTH-1:0] rhs_eff;

   assign is_sub  = (op == ALU_SUB);
   assign rhs_eff = is_sub ? ~rhs : rhs;

   // On subtract, carry high means no borrow (lhs >= rhs).
   assign {carry, result} = {1'b0, lhs} + {1'b0, rhs_eff} + {{WIDTH{1'b0}}, is_sub};

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for gcd_lcm_unit: directed and random operand pairs.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // -------------------------------------------------------------------------
   // Clock, reset and ports
   // -------------------------------------------------------------------------
   localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles allowed before the timeout
   localparam int SETTLE_CYCLES  = 300;    // after the last result, catch strays
   localparam int MAX_GAP        = 16;     // longest sender pause between items

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_operand_a = '0;
   logic [15:0] req_operand_b = '0;
   logic        rsp_valid;
   logic [15:0] rsp_gcd_value;
   logic [31:0] rsp_lcm_value;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   gcd_lcm_unit #(
      .OPERAND_WIDTH(16)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid    (rsp_valid),
      .rsp_gcd_value(rsp_gcd_value),
      .rsp_lcm_value(rsp_lcm_value)
   );

   // -------------------------------------------------------------------------
   // Predictor: Euclid's algorithm, then lcm = (a / gcd) * b.
   // A zero operand skips the search: gcd reads 1 and lcm reads 0.
   // -------------------------------------------------------------------------
   typedef struct {
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [15:0] gcd_value;
      logic [31:0] lcm_value;
   } gcd_lcm_result_type;

   gcd_lcm_result_type pending_results[$];   // expected results, oldest first
   int                 error_count = 0;
   int                 sender_idle_pct = 0;  // chance of a pause after each transfer

   function automatic gcd_lcm_result_type predict_gcd_lcm(input logic [15:0] a,
                                                          input logic [15:0] b);
      gcd_lcm_result_type res;
      logic [15:0]        x;
      logic [15:0]        y;
      logic [15:0]        r;
      res.operand_a = a;
      res.operand_b = b;
      res.gcd_value = 16'd1;
      res.lcm_value = 32'd0;
      if (a != 0 && b != 0) begin
         x = a;
         y = b;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         res.gcd_value = x;
         // full 32-bit product; 16 x 16 bits never overflows
         res.lcm_value = 32'(a / x) * 32'(b);
      end
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Sender: one transfer per call. start and the operands are held until the
   // block takes them (start high, busy low at the edge). start is only
   // lowered when a pause follows, so a back-to-back item never sees start
   // dropped and raised within the same time step.
   // -------------------------------------------------------------------------
   task automatic send_operands(input logic [15:0] a, input logic [15:0] b);
      int gap;
      start         <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      do
         @(posedge clock);
      while (busy);
      pending_results.push_back(predict_gcd_lcm(a, b));
      if ($urandom_range(99, 0) < sender_idle_pct) begin
         gap = $urandom_range(MAX_GAP, 1);
         start <= 1'b0;
         // junk on the operand lines while idle; must be ignored
         req_operand_a <= 16'($urandom);
         req_operand_b <= 16'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_results_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Operand pairs shaped to exercise each part of the sequencer: common
   // twos, long odd reductions, large shared factors, zero shortcuts.
   task automatic pick_operands(output logic [15:0] a, output logic [15:0] b);
      int          kind;
      int unsigned common;
      kind = $urandom_range(9, 0);
      case (kind)
         0, 1, 2: begin
            a = 16'($urandom);
            b = 16'($urandom);
         end
         3, 4: begin
            // shared factor so the gcd is large
            common = $urandom_range(4095, 1);
            a = 16'(common * $urandom_range(65535 / common, 1));
            b = 16'(common * $urandom_range(65535 / common, 1));
         end
         5: begin
            // odd values scaled by powers of two: many common twos
            a = 16'(($urandom_range(255, 1) | 1) << $urandom_range(8, 0));
            b = 16'(($urandom_range(255, 1) | 1) << $urandom_range(8, 0));
         end
         6: begin
            // one or both operands zero
            a = $urandom_range(1, 0) ? 16'd0 : 16'($urandom);
            b = (a != 0 || $urandom_range(1, 0)) ? 16'd0 : 16'($urandom);
         end
         7: begin
            a = 16'($urandom);
            b = a;
         end
         8: begin
            a = 16'($urandom_range(15, 1));
            b = 16'($urandom);
         end
         default: begin
            // near the top of the range
            a = 16'(65535 - $urandom_range(63, 0));
            b = 16'(65535 - $urandom_range(63, 0));
         end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Zero operands, equal operands, range extremes, coprime and shared-factor
   // pairs, both operand orders.
   task automatic test_directed_operands();
      send_operands(16'd0,     16'd0);
      send_operands(16'd0,     16'd1);
      send_operands(16'd1,     16'd0);
      send_operands(16'd0,     16'd65535);
      send_operands(16'd65535, 16'd0);
      send_operands(16'd1,     16'd1);
      send_operands(16'd65535, 16'd65535);
      send_operands(16'd12345, 16'd12345);
      send_operands(16'd65535, 16'd65534);
      send_operands(16'd65534, 16'd65535);
      send_operands(16'd1,     16'd65535);
      send_operands(16'd32768, 16'd32768);
      send_operands(16'd32768, 16'd1);
      send_operands(16'd32768, 16'd49152);
      send_operands(16'd65534, 16'd32767);
      send_operands(16'd12,    16'd18);
      send_operands(16'd18,    16'd12);
      send_operands(16'd65521, 16'd65519);
      send_operands(16'd4096,  16'd6144);
      send_operands(16'd43690, 16'd21845);
   endtask

   task automatic test_random_operands(input int count);
      logic [15:0] a;
      logic [15:0] b;
      repeat (count) begin
         pick_operands(a, b);
         send_operands(a, b);
      end
   endtask

   // Bursts separated by a full drain: the block goes idle with nothing in
   // flight, then has to start clean.
   task automatic test_bursts_after_drain(input int bursts);
      repeat (bursts) begin
         test_random_operands($urandom_range(12, 1));
         start <= 1'b0;
         @(posedge clock);
         wait_results_drained();
         repeat ($urandom_range(MAX_GAP, 1)) @(posedge clock);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result checker: every strobe is a transfer and must match the oldest
   // expectation, field by field.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      gcd_lcm_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result: expected none, got gcd %0d lcm %0d",
                     $time, rsp_gcd_value, rsp_lcm_value);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_gcd_value !== exp_res.gcd_value) begin
               $display("%0t ns: gcd mismatch for a=%0d b=%0d: expected %0d, got %0d",
                        $time, exp_res.operand_a, exp_res.operand_b,
                        exp_res.gcd_value, rsp_gcd_value);
               error_count++;
            end
            if (rsp_lcm_value !== exp_res.lcm_value) begin
               $display("%0t ns: lcm mismatch for a=%0d b=%0d: expected %0d, got %0d",
                        $time, exp_res.operand_a, exp_res.operand_b,
                        exp_res.lcm_value, rsp_lcm_value);
               error_count++;
            end
         end
      end
   end

   // Watchdog: restarts on any transfer in either direction.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: timeout, no transfer for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence: reset, directed, then random in three idling profiles
   // (sender pausing 12%, 60%, never), with drained bursts after the first.
   // -------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 12;
      test_directed_operands();
      test_random_operands(500);

      test_bursts_after_drain(6);

      sender_idle_pct = 60;
      test_random_operands(500);

      sender_idle_pct = 0;
      test_random_operands(500);

      start <= 1'b0;
      @(posedge clock);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
